>>> rtl/core/eshf_pkg.sv
// Shared types, constants and helpers for the sentence hex framer.
`timescale 1ns / 1ps
`default_nettype none

package eshf_pkg;

    // Orbit data bytes that follow the satellite number in one sentence.
    localparam int DATA_BYTES = 72;
    localparam int POS_W      = 8;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH  = 4;
    localparam int PTR_W      = $clog2(CMD_DEPTH);
    localparam int CNT_W      = $clog2(CMD_DEPTH + 1);

    // Character index within one command.
    localparam int IDX_W      = 4;

    localparam int LEAD_LEN   = 9;

    // "$" followed by the sentence tag and comma.
    localparam logic [7:0] LEAD_TEXT [0:LEAD_LEN-1] = '{
        8'h24, 8'h50, 8'h4D, 8'h54, 8'h4B, 8'h37, 8'h32, 8'h31, 8'h2C
    };

    // XOR of the lead characters after '$'.
    localparam logic [7:0] LEAD_XOR   = 8'h1A;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Character slots per command kind.
    localparam logic [IDX_W-1:0] IDX_FIRST_HI  = IDX_W'(LEAD_LEN);
    localparam logic [IDX_W-1:0] IDX_FIRST_END = IDX_W'(LEAD_LEN + 1);
    localparam logic [IDX_W-1:0] IDX_HEX_HI    = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_HEX_LO    = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_STAR      = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_SUM_HI    = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_SUM_LO    = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_CR        = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_LF        = IDX_W'(6);

    typedef enum logic [1:0] {
        KIND_FIRST = 2'd0,
        KIND_MID   = 2'd1,
        KIND_LAST  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] sum;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_cmd_wr;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'h0, nib};
        end else begin
            r = 8'h37 + {4'h0, nib};
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_pair_xor(input logic [7:0] v);
        return hex_digit(v[7:4]) ^ hex_digit(v[3:0]);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/eshf_front.sv
// Front end: accepts bytes, tracks sentence position and checksum, issues commands.
`timescale 1ns / 1ps
`default_nettype none

module eshf_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    output eshf_pkg::t_cmd_wr    o_wr
);

    logic [eshf_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_xor, n_xor;
    logic [7:0]                 hex_x;
    eshf_pkg::t_cmd             cmd;

    assign hex_x = eshf_pkg::hex_pair_xor(i_data_byte);

    always_comb begin
        n_pos    = r_pos;
        n_xor    = r_xor;
        cmd.data = i_data_byte;
        cmd.sum  = r_xor ^ hex_x;
        cmd.kind = eshf_pkg::KIND_MID;
        priority if (r_pos == '0) begin
            cmd.kind = eshf_pkg::KIND_FIRST;
            cmd.sum  = eshf_pkg::LEAD_XOR ^ hex_x;
            n_pos    = eshf_pkg::POS_W'(1);
            n_xor    = eshf_pkg::LEAD_XOR ^ hex_x;
        end else if (r_pos >= eshf_pkg::POS_W'(eshf_pkg::DATA_BYTES)) begin
            // out-of-range positions also close the sentence
            cmd.kind = eshf_pkg::KIND_LAST;
            n_pos    = '0;
            n_xor    = '0;
        end else begin
            n_pos    = r_pos + eshf_pkg::POS_W'(1);
            n_xor    = r_xor ^ hex_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_xor <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_xor <= n_xor;
        end
    end

    assign o_wr.push = i_accept;
    assign o_wr.cmd  = cmd;

endmodule

`default_nettype wire

>>> rtl/core/eshf_cmd_fifo.sv
// Small command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module eshf_cmd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  eshf_pkg::t_cmd_wr    i_wr,
    output logic                 o_full,
    input  wire logic            i_rd,
    output logic                 o_valid,
    output eshf_pkg::t_cmd       o_cmd
);

    eshf_pkg::t_cmd                  r_mem [eshf_pkg::CMD_DEPTH];
    logic [eshf_pkg::PTR_W-1:0]      r_wptr, r_rptr;
    logic [eshf_pkg::CNT_W-1:0]      r_count;
    logic                            do_wr, do_rd;

    localparam logic [eshf_pkg::PTR_W-1:0] PTR_LAST =
        eshf_pkg::PTR_W'(eshf_pkg::CMD_DEPTH - 1);

    assign o_full  = (r_count == eshf_pkg::CNT_W'(eshf_pkg::CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_wr   = i_wr.push && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + eshf_pkg::PTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + eshf_pkg::PTR_W'(1);
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + eshf_pkg::CNT_W'(1);
                2'b01:   r_count <= r_count - eshf_pkg::CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/eshf_back.sv
// Back end: commands to characters in an output register, one per cycle unless held.
`timescale 1ns / 1ps
`default_nettype none

module eshf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  eshf_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_rd,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output logic [7:0]           o_out_char,
    output logic                 o_last_of_item,
    output logic                 o_end_of_sentence
);

    eshf_pkg::t_cmd              r_ent;
    logic                        r_busy;
    logic [eshf_pkg::IDX_W-1:0]  r_idx;

    logic                        r_out_valid;
    logic [7:0]                  r_char;
    logic                        r_last;
    logic                        r_eos;

    logic                        load_out, emit, done, fetch;
    logic [eshf_pkg::IDX_W-1:0]  last_idx;
    logic [7:0]                  ch;
    logic                        eos;

    always_comb begin
        ch       = eshf_pkg::hex_digit(r_ent.data[7:4]);
        eos      = 1'b0;
        last_idx = eshf_pkg::IDX_HEX_LO;
        unique case (r_ent.kind)
            eshf_pkg::KIND_FIRST: begin
                last_idx = eshf_pkg::IDX_FIRST_END;
                priority if (r_idx < eshf_pkg::IDX_FIRST_HI) begin
                    ch = eshf_pkg::LEAD_TEXT[r_idx];
                end else if (r_idx == eshf_pkg::IDX_FIRST_HI) begin
                    ch = eshf_pkg::hex_digit(r_ent.data[7:4]);
                end else begin
                    ch = eshf_pkg::hex_digit(r_ent.data[3:0]);
                end
            end
            eshf_pkg::KIND_LAST: begin
                last_idx = eshf_pkg::IDX_LF;
                priority if (r_idx == eshf_pkg::IDX_HEX_HI) begin
                    ch = eshf_pkg::hex_digit(r_ent.data[7:4]);
                end else if (r_idx == eshf_pkg::IDX_HEX_LO) begin
                    ch = eshf_pkg::hex_digit(r_ent.data[3:0]);
                end else if (r_idx == eshf_pkg::IDX_STAR) begin
                    ch = eshf_pkg::CHAR_STAR;
                end else if (r_idx == eshf_pkg::IDX_SUM_HI) begin
                    ch = eshf_pkg::hex_digit(r_ent.sum[7:4]);
                end else if (r_idx == eshf_pkg::IDX_SUM_LO) begin
                    ch = eshf_pkg::hex_digit(r_ent.sum[3:0]);
                end else if (r_idx == eshf_pkg::IDX_CR) begin
                    ch = eshf_pkg::CHAR_CR;
                end else begin
                    ch  = eshf_pkg::CHAR_LF;
                    eos = 1'b1;
                end
            end
            eshf_pkg::KIND_MID: begin
                last_idx = eshf_pkg::IDX_HEX_LO;
                ch = (r_idx == eshf_pkg::IDX_HEX_HI) ? eshf_pkg::hex_digit(r_ent.data[7:4])
                                                     : eshf_pkg::hex_digit(r_ent.data[3:0]);
            end
            default: begin
                last_idx = eshf_pkg::IDX_HEX_LO;
                ch       = eshf_pkg::hex_digit(r_ent.data[3:0]);
            end
        endcase
    end

    assign load_out = !r_out_valid || i_pop;
    assign emit     = r_busy && load_out;
    assign done     = emit && (r_idx == last_idx);
    // next command is picked up in the same cycle the current one finishes
    assign fetch    = i_cmd_valid && (!r_busy || done);
    assign o_cmd_rd = fetch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (fetch) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_idx  <= r_idx + eshf_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_ent <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= ch;
            r_last <= done;
            r_eos  <= eos;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out_char        = r_char;
    assign o_last_of_item    = r_last;
    assign o_end_of_sentence = r_eos;

endmodule

`default_nettype wire

>>> rtl/core/ephemeris_sentence_hex_framer.sv
// Top level of the ephemeris sentence hex framer.
//
// Turns a byte stream into ASCII sentences: each group of one satellite number
// plus DATA_BYTES orbit bytes (package constant, 72) becomes the lead text,
// every byte as two upper-case hex digits, '*', a two-digit XOR checksum of
// all characters between '$' and '*', then CR LF. Input side is a queue write
// port (push/full), output side a queue read port (empty/pop); one transaction
// on the output carries one character. The front end classifies each byte and
// folds it into the running checksum in the cycle it is taken, then writes a
// command into a 4-entry queue, so full is only high while that queue is full.
// The back end turns commands into characters at one per cycle while the output
// is empty or popped, through a single output register, and starts the next
// command in the cycle the current one finishes. An orbit data byte gives two
// characters, the satellite byte eleven and the closing byte seven, with no gap
// between commands while pop stays high and commands wait. The block has no
// configuration. A byte goes through the queue, r_ent and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ephemeris_sentence_hex_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_char,
    output logic             o_last_of_item,
    output logic             o_end_of_sentence
);

    eshf_pkg::t_cmd_wr  wr;
    eshf_pkg::t_cmd     q_cmd;
    logic               q_valid;
    logic               q_rd;
    logic               out_valid;
    logic               accept;

    assign accept = push && !full;

    // classify and checksum
    eshf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_wr        (wr)
    );

    // decouples byte intake from character output
    eshf_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // character generator and output register
    eshf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (q_valid),
        .i_cmd             (q_cmd),
        .o_cmd_rd          (q_rd),
        .o_valid           (out_valid),
        .i_pop             (pop),
        .o_out_char        (o_out_char),
        .o_last_of_item    (o_last_of_item),
        .o_end_of_sentence (o_end_of_sentence)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire
